FILE: src/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg: shared types and constants
// Register indexes, item kinds and the queue entry format.
// ----------------------------------------------------------------------------
package dtt_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_TOD   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    REG_PRA   = 4'd0,
    REG_PRB   = 4'd1,
    REG_DDRA  = 4'd2,
    REG_DDRB  = 4'd3,
    REG_TALO  = 4'd4,
    REG_TAHI  = 4'd5,
    REG_TBLO  = 4'd6,
    REG_TBHI  = 4'd7,
    REG_TODLO = 4'd8,
    REG_TODMD = 4'd9,
    REG_TODHI = 4'd10,
    REG_NONE  = 4'd11,
    REG_SDR   = 4'd12,
    REG_ICR   = 4'd13,
    REG_CRA   = 4'd14,
    REG_CRB   = 4'd15
  } reg_e;

  // classified item passed from front to back
  typedef struct packed {
    mode_e       mode;
    reg_e        idx;
    logic [7:0]  data;
  } item_t;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;

endpackage

FILE: src/dtt_front.sv
// ----------------------------------------------------------------------------
// dtt_front: input queue
// Takes items from the bus and holds them in a short queue for the core.
// ----------------------------------------------------------------------------
module dtt_front import dtt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [3:0] reg_index_i,
  input  logic [7:0] write_data_i,
  output logic       q_valid_o,
  input  logic       q_ready_i,
  output item_t      q_item_o
);

  item_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QPtrW:0]    cnt_q, cnt_d;
  logic              push, pop;

  assign in_ready_o = (cnt_q != (QPtrW+1)'(QDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign push       = in_valid_i & in_ready_o;
  assign pop        = q_valid_o & q_ready_i;
  assign q_item_o   = mem_q[rd_q];

  // pointer and fill update
  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_t'{mode: mode_e'(mode_i), idx: reg_e'(reg_index_i),
                             data: write_data_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPtrW+1)'(QDepth)) else $error("queue overfill");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("fill count slip");

endmodule

FILE: src/dtt_core.sv
// ----------------------------------------------------------------------------
// dtt_core: register file, timers and time of day
// Executes one queued item per cycle into an output register, unless a held result stalls it.
// ----------------------------------------------------------------------------
module dtt_core import dtt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  output logic       q_ready_o,
  input  item_t      q_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       irq_o
);

  logic [15:0] cnta_q, cnta_d, cntb_q, cntb_d, rela_q, rela_d, relb_q, relb_d;
  logic [7:0]  cra_q, cra_d, crb_q, crb_d;
  logic [23:0] tod_q, tod_d, alm_q, alm_d, tod_inc;
  logic        halt_q, halt_d;
  logic [6:0]  mask_q, mask_d;
  logic [4:0]  flg_q, flg_d;
  logic [7:0]  pra_q, pra_d, prb_q, prb_d, ddra_q, ddra_d, ddrb_q, ddrb_d;
  logic [7:0]  sdr_q, sdr_d;
  logic        ov_q, ov_d, irq_q, irq_d;
  logic [7:0]  rd_q, rd_d;
  logic        go;
  logic [7:0]  v;
  logic [15:0] cnta_m1, cntb_m1;

  assign q_ready_o   = !ov_q || out_ready_i;
  assign go          = q_valid_i && q_ready_o;
  assign out_valid_o = ov_q;
  assign read_data_o = rd_q;
  assign irq_o       = irq_q;
  assign v           = q_item_i.data;
  assign cnta_m1     = cnta_q - 16'd1;
  assign cntb_m1     = cntb_q - 16'd1;
  assign tod_inc     = tod_q + 24'd1;

  // item execution
  always_comb begin
    cnta_d = cnta_q; cntb_d = cntb_q; rela_d = rela_q; relb_d = relb_q;
    cra_d = cra_q; crb_d = crb_q; tod_d = tod_q; alm_d = alm_q;
    halt_d = halt_q; mask_d = mask_q; flg_d = flg_q;
    pra_d = pra_q; prb_d = prb_q; ddra_d = ddra_q; ddrb_d = ddrb_q; sdr_d = sdr_q;
    rd_d = 8'd0;
    ov_d = ov_q && !out_ready_i;
    if (go) begin
      ov_d = 1'b1;
      unique case (q_item_i.mode)
        MODE_WRITE: begin
          unique case (q_item_i.idx)
            REG_PRA:  pra_d = {pra_q[7:2], v[1:0]};
            REG_PRB:  prb_d = v;
            REG_DDRA: ddra_d = v;
            REG_DDRB: ddrb_d = v;
            REG_TALO: begin
              rela_d = {rela_q[15:8], v};
              if (!cra_q[0]) cnta_d = {cnta_q[15:8], v};
            end
            REG_TAHI: begin
              rela_d = {v, rela_q[7:0]};
              if (cra_q[3]) begin
                cnta_d = {v, rela_q[7:0]};
                cra_d  = cra_q | 8'h01;
              end else if (!cra_q[0]) cnta_d = {v, rela_q[7:0]};
            end
            REG_TBLO: begin
              relb_d = {relb_q[15:8], v};
              if (!crb_q[0]) cntb_d = {cntb_q[15:8], v};
            end
            REG_TBHI: begin
              relb_d = {v, relb_q[7:0]};
              if (crb_q[3]) begin
                cntb_d = {v, relb_q[7:0]};
                crb_d  = crb_q | 8'h01;
              end else if (!crb_q[0]) cntb_d = {v, relb_q[7:0]};
            end
            REG_TODLO: begin
              if (crb_q[7]) alm_d = {alm_q[23:8], v};
              else begin tod_d = {tod_q[23:8], v}; halt_d = 1'b0; end
            end
            REG_TODMD: begin
              if (crb_q[7]) alm_d = {alm_q[23:16], v, alm_q[7:0]};
              else begin tod_d = {tod_q[23:16], v, tod_q[7:0]}; halt_d = 1'b1; end
            end
            REG_TODHI: begin
              if (crb_q[7]) alm_d = {v, alm_q[15:0]};
              else begin tod_d = {v, tod_q[15:0]}; halt_d = 1'b1; end
            end
            REG_SDR: begin
              sdr_d = v;
              if (mask_q[3]) flg_d = flg_q | 5'h08;
            end
            REG_ICR: mask_d = v[7] ? (mask_q | v[6:0]) : (mask_q & ~v[6:0]);
            REG_CRA: begin
              if (v[4]) cnta_d = rela_q;
              cra_d = v & 8'hEF;
            end
            REG_CRB: begin
              if (v[4]) cntb_d = relb_q;
              crb_d = v & 8'hEF;
            end
            default: ;
          endcase
        end
        MODE_READ: begin
          unique case (q_item_i.idx)
            REG_PRA:   rd_d = pra_q;
            REG_PRB:   rd_d = prb_q;
            REG_DDRA:  rd_d = ddra_q;
            REG_DDRB:  rd_d = ddrb_q;
            REG_TALO:  rd_d = cnta_q[7:0];
            REG_TAHI:  rd_d = cnta_q[15:8];
            REG_TBLO:  rd_d = cntb_q[7:0];
            REG_TBHI:  rd_d = cntb_q[15:8];
            REG_TODLO: rd_d = tod_q[7:0];
            REG_TODMD: rd_d = tod_q[15:8];
            REG_TODHI: rd_d = tod_q[23:16];
            REG_SDR:   rd_d = sdr_q;
            REG_ICR: begin
              rd_d  = {(flg_q != 5'd0), 2'b00, flg_q};
              flg_d = 5'd0;
            end
            REG_CRA:   rd_d = cra_q;
            REG_CRB:   rd_d = crb_q;
            default:   rd_d = 8'd0;
          endcase
        end
        MODE_TICK: begin
          if (cra_q[0]) begin
            if (cnta_q == 16'd0) begin
              cnta_d = rela_q;
              if (cra_q[3]) cra_d = cra_q & 8'hFE;
              if (mask_q[0]) flg_d[0] = 1'b1;
            end else cnta_d = cnta_m1;
          end
          if (crb_q[0]) begin
            if (cntb_q == 16'd0) begin
              cntb_d = relb_q;
              if (crb_q[3]) crb_d = crb_q & 8'hFE;
              if (mask_q[1]) flg_d[1] = 1'b1;
            end else cntb_d = cntb_m1;
          end
        end
        MODE_TOD: begin
          if (!halt_q) begin
            tod_d = tod_inc;
            if (mask_q[2] && tod_inc == alm_q) flg_d[2] = 1'b1;
          end
        end
        default: ;
      endcase
    end
    irq_d = go ? (flg_d != 5'd0) : irq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnta_q <= '0; cntb_q <= '0; rela_q <= '1; relb_q <= '1;
      cra_q <= '0; crb_q <= '0; tod_q <= '0; alm_q <= '1; halt_q <= 1'b0;
      mask_q <= '1; flg_q <= 5'h08; pra_q <= 8'hFF; prb_q <= '0;
      ddra_q <= '0; ddrb_q <= '0; sdr_q <= '0;
      ov_q <= 1'b0; irq_q <= 1'b0;
    end else begin
      cnta_q <= cnta_d; cntb_q <= cntb_d; rela_q <= rela_d; relb_q <= relb_d;
      cra_q <= cra_d; crb_q <= crb_d; tod_q <= tod_d; alm_q <= alm_d;
      halt_q <= halt_d; mask_q <= mask_d; flg_q <= flg_d;
      pra_q <= pra_d; prb_q <= prb_d; ddra_q <= ddra_d; ddrb_q <= ddrb_d;
      sdr_q <= sdr_d; ov_q <= ov_d; irq_q <= irq_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (go) rd_q <= rd_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(rd_q)) else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && q_item_i.mode == MODE_READ && q_item_i.idx == REG_ICR) |=> (flg_q == 5'd0))
    else $error("flag read did not clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> (irq_q == (flg_q != 5'd0))) else $error("irq mismatch");

endmodule

FILE: src/dual_timer_tod_interrupt_unit.sv
// ----------------------------------------------------------------------------
// dual_timer_tod_interrupt_unit: timers, time of day and interrupt control
// Bus items are queued by the front end and executed by the core.
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | input     | in_valid_i/in_ready_o, mode_i, reg_index_i, write_data_i
// out     | output    | out_valid_o/out_ready_i, read_data_o, irq_o
//
// One item per cycle sustained while out_ready_i stays high; an item passes through the queue, then the core register.
// The core executes each item from the queue head.
// Reset empties the queue and sets the core registers, but for the result payload, to their power-up values at once.
// A stalled result holds the core; the two-entry queue then fills and
// in_ready_o drops.
module dual_timer_tod_interrupt_unit import dtt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [3:0] reg_index_i,
  input  logic [7:0] write_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       irq_o
);

  logic  q_valid, q_ready;
  item_t q_item;

  dtt_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .reg_index_i,
    .write_data_i, .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  dtt_core u_core (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o, .out_ready_i, .read_data_o, .irq_o
  );

endmodule
